/* hdl/spc_pkg.sv */
// Package for the service port collision checker.
// Holds table sizes, derived widths, request and result types and helpers.
// Depends on nothing.
package spc_pkg;

  localparam int SERVICE_ENTRIES = 1024;
  localparam int PORT_ENTRIES    = 1024;
  localparam int PROVIDER_BITS   = 8;
  localparam int KEY_SHIFT       = 16;

  localparam int KEY_W          = 2 * KEY_SHIFT;
  localparam int PORT_W         = 16;
  localparam int SVC_AW         = $clog2(SERVICE_ENTRIES);
  localparam int SVC_CW         = SVC_AW + 1;
  localparam int PORT_AW        = $clog2(PORT_ENTRIES);
  localparam int PORT_CW        = PORT_AW + 1;
  localparam int IDX_W          = (SVC_CW > PORT_CW) ? SVC_CW : PORT_CW;
  localparam int SVC_ENTRY_W    = KEY_W + PROVIDER_BITS;
  localparam int PORT_ENTRY_W   = PROVIDER_BITS + PORT_W;

  typedef struct packed {
    logic [15:0] service_code;
    logic [15:0] instance_code;
    logic [7:0]  provider_code;
    logic [15:0] port_number;
    logic        first_of_set;
  } spc_in_t;

  typedef struct packed {
    logic       service_collision;
    logic [7:0] earlier_provider;
    logic       port_conflict;
    logic       table_overflow;
  } spc_out_t;

  // Keeps only the low PROVIDER_BITS bits of a provider code.
  function automatic logic [PROVIDER_BITS-1:0] prov_of(input logic [7:0] code);
    logic [15:0] wide;
    wide = {8'b0, code};
    return wide[PROVIDER_BITS-1:0];
  endfunction

  // Widens or narrows a stored provider to the 8-bit result field.
  function automatic logic [7:0] prov_out(input logic [PROVIDER_BITS-1:0] prov);
    logic [15:0] wide;
    wide = 16'(prov);
    return wide[7:0];
  endfunction

endpackage

/* hdl/service_port_collision_checker_top.sv */
// Top level of the service port collision checker.
// Instantiates the sequencer spc_seq and two spc_ram tables; depends on spc_pkg.
//
// Each request is checked against a service table of keys with their first
// provider and a port table of provider and port pairs, both filled in order
// and bounded by fill counters, so no clearing pass is ever needed. A request
// with first_of_set high resets both counters. A request is accepted in the
// idle state, then both tables are scanned entry by entry (each table's scan
// ends at its match or at its fill count, and the longer of the two sets the
// length), then the insert is made in the done state. The single read port
// of each table, shared by one scan index, sets the length of the scan. A
// finished result waits in an output register while the next request runs,
// and the insert cycle waits while an earlier result is still unaccepted.
module service_port_collision_checker_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  spc_pkg::spc_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output spc_pkg::spc_out_t  out_data_o
);
  import spc_pkg::*;

  logic [SVC_AW-1:0]       svc_raddr, svc_waddr;
  logic [SVC_ENTRY_W-1:0]  svc_rdata, svc_wdata;
  logic                    svc_we;
  logic [PORT_AW-1:0]      port_raddr, port_waddr;
  logic [PORT_ENTRY_W-1:0] port_rdata, port_wdata;
  logic                    port_we;

  spc_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o),
    .svc_raddr_o  (svc_raddr),
    .svc_rdata_i  (svc_rdata),
    .svc_we_o     (svc_we),
    .svc_waddr_o  (svc_waddr),
    .svc_wdata_o  (svc_wdata),
    .port_raddr_o (port_raddr),
    .port_rdata_i (port_rdata),
    .port_we_o    (port_we),
    .port_waddr_o (port_waddr),
    .port_wdata_o (port_wdata)
  );

  spc_ram #(
    .WIDTH (SVC_ENTRY_W),
    .DEPTH (SERVICE_ENTRIES)
  ) u_svc_ram (
    .clk_i   (clk_i),
    .we_i    (svc_we),
    .waddr_i (svc_waddr),
    .wdata_i (svc_wdata),
    .raddr_i (svc_raddr),
    .rdata_o (svc_rdata)
  );

  spc_ram #(
    .WIDTH (PORT_ENTRY_W),
    .DEPTH (PORT_ENTRIES)
  ) u_port_ram (
    .clk_i   (clk_i),
    .we_i    (port_we),
    .waddr_i (port_waddr),
    .wdata_i (port_wdata),
    .raddr_i (port_raddr),
    .rdata_o (port_rdata)
  );

endmodule

/* hdl/spc_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
// Used for the service table and the port table. Depends on nothing.
module spc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/spc_seq.sv */
// Sequencer and shared compare logic of the service port collision checker.
// Scans both tables with one index, then inserts and loads the result register.
// Depends on spc_pkg.
module spc_seq (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  spc_pkg::spc_in_t                        in_data_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output spc_pkg::spc_out_t                       out_data_o,
  output logic [spc_pkg::SVC_AW-1:0]              svc_raddr_o,
  input  logic [spc_pkg::SVC_ENTRY_W-1:0]         svc_rdata_i,
  output logic                                    svc_we_o,
  output logic [spc_pkg::SVC_AW-1:0]              svc_waddr_o,
  output logic [spc_pkg::SVC_ENTRY_W-1:0]         svc_wdata_o,
  output logic [spc_pkg::PORT_AW-1:0]             port_raddr_o,
  input  logic [spc_pkg::PORT_ENTRY_W-1:0]        port_rdata_i,
  output logic                                    port_we_o,
  output logic [spc_pkg::PORT_AW-1:0]             port_waddr_o,
  output logic [spc_pkg::PORT_ENTRY_W-1:0]        port_wdata_o
);
  import spc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]               state_q, state_d;
  logic [IDX_W-1:0]         idx_q, idx_d;
  logic                     pend_q, pend_d;
  logic                     svc_done_q, svc_done_d;
  logic                     svc_hit_q, svc_hit_d;
  logic                     port_done_q, port_done_d;
  logic                     port_hit_q, port_hit_d;
  logic                     collide_q, collide_d;
  logic [PROVIDER_BITS-1:0] earlier_q, earlier_d;
  logic [SVC_CW-1:0]        svc_cnt_q, svc_cnt_d;
  logic [PORT_CW-1:0]       port_cnt_q, port_cnt_d;
  logic                     out_valid_q, out_valid_d;

  logic [KEY_W-1:0]         key_q, key_d;
  logic [PROVIDER_BITS-1:0] prov_q, prov_d;
  logic [PORT_W-1:0]        port_q, port_d;
  spc_out_t                 out_q, out_d;

  logic svc_match, port_match, svc_done_n, port_done_n;
  logic svc_full, port_full, out_free, load;

  assign svc_match  = pend_q && !svc_done_q &&
                      (svc_rdata_i[SVC_ENTRY_W-1 -: KEY_W] == key_q);
  assign port_match = pend_q && !port_done_q && (port_rdata_i == {prov_q, port_q});
  assign svc_done_n  = svc_done_q || svc_match || (idx_q >= IDX_W'(svc_cnt_q));
  assign port_done_n = port_done_q || port_match || (idx_q >= IDX_W'(port_cnt_q));
  assign svc_full  = (svc_cnt_q == SVC_CW'(SERVICE_ENTRIES));
  assign port_full = (port_cnt_q == PORT_CW'(PORT_ENTRIES));
  assign out_free  = !out_valid_q || out_ready_i;
  assign load      = (state_q == ST_DONE) && out_free;

  assign in_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_q;
  assign svc_raddr_o  = idx_q[SVC_AW-1:0];
  assign port_raddr_o = idx_q[PORT_AW-1:0];
  assign svc_waddr_o  = svc_cnt_q[SVC_AW-1:0];
  assign port_waddr_o = port_cnt_q[PORT_AW-1:0];
  assign svc_wdata_o  = {key_q, prov_q};
  assign port_wdata_o = {prov_q, port_q};
  assign svc_we_o     = load && !svc_hit_q && !svc_full;
  assign port_we_o    = load && !port_hit_q && !port_full;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    pend_d      = pend_q;
    svc_done_d  = svc_done_q;
    svc_hit_d   = svc_hit_q;
    port_done_d = port_done_q;
    port_hit_d  = port_hit_q;
    collide_d   = collide_q;
    earlier_d   = earlier_q;
    svc_cnt_d   = svc_cnt_q;
    port_cnt_d  = port_cnt_q;
    key_d       = key_q;
    prov_d      = prov_q;
    port_d      = port_q;
    out_d       = out_q;
    out_valid_d = out_ready_i ? 1'b0 : out_valid_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          key_d       = {in_data_i.service_code, in_data_i.instance_code};
          prov_d      = prov_of(in_data_i.provider_code);
          port_d      = in_data_i.port_number;
          idx_d       = '0;
          pend_d      = 1'b0;
          svc_done_d  = 1'b0;
          svc_hit_d   = 1'b0;
          port_done_d = 1'b0;
          port_hit_d  = 1'b0;
          collide_d   = 1'b0;
          earlier_d   = '0;
          if (in_data_i.first_of_set) begin
            svc_cnt_d  = '0;
            port_cnt_d = '0;
          end
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        pend_d      = 1'b1;
        idx_d       = idx_q + IDX_W'(1);
        svc_done_d  = svc_done_n;
        port_done_d = port_done_n;
        if (svc_match) begin
          svc_hit_d = 1'b1;
          if (svc_rdata_i[PROVIDER_BITS-1:0] != prov_q) begin
            collide_d = 1'b1;
            earlier_d = svc_rdata_i[PROVIDER_BITS-1:0];
          end
        end
        if (port_match) begin
          port_hit_d = 1'b1;
        end
        if (svc_done_n && port_done_n) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_d.service_collision = collide_q;
          out_d.earlier_provider  = prov_out(earlier_q);
          out_d.port_conflict     = port_hit_q;
          out_d.table_overflow    = (!svc_hit_q && svc_full) || (!port_hit_q && port_full);
          out_valid_d             = 1'b1;
          if (!svc_hit_q && !svc_full) begin
            svc_cnt_d = svc_cnt_q + SVC_CW'(1);
          end
          if (!port_hit_q && !port_full) begin
            port_cnt_d = port_cnt_q + PORT_CW'(1);
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      svc_done_q  <= 1'b0;
      svc_hit_q   <= 1'b0;
      port_done_q <= 1'b0;
      port_hit_q  <= 1'b0;
      collide_q   <= 1'b0;
      earlier_q   <= '0;
      svc_cnt_q   <= '0;
      port_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      svc_done_q  <= svc_done_d;
      svc_hit_q   <= svc_hit_d;
      port_done_q <= port_done_d;
      port_hit_q  <= port_hit_d;
      collide_q   <= collide_d;
      earlier_q   <= earlier_d;
      svc_cnt_q   <= svc_cnt_d;
      port_cnt_q  <= port_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    prov_q <= prov_d;
    port_q <= port_d;
    out_q  <= out_d;
  end

endmodule
